// ----- hdl/mbc_pkg.sv -----
// ----------------------------------------------------------------------------
// mbc_pkg
// Shared constants, types and controller/datapath links for the maze carver.
// ----------------------------------------------------------------------------
package mbc_pkg;

	localparam int MAX_WIDTH   = 32;
	localparam int MAX_HEIGHT  = 32;
	localparam int DIR_COUNT   = 4;
	localparam int COORD_W     = 5;
	localparam int CFG_W       = 6;
	localparam int STACK_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int CELL_AW     = $clog2(STACK_DEPTH);
	localparam int DEPTH_W     = CELL_AW + 1;
	localparam int TRIED_W     = 3;
	localparam int EPOCH_W     = 4;
	localparam int ENTRY_W     = 2 * COORD_W + 2 + TRIED_W;

	localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

	// directions
	localparam logic [1:0] DIR_WEST  = 2'd0;
	localparam logic [1:0] DIR_SOUTH = 2'd1;
	localparam logic [1:0] DIR_EAST  = 2'd2;
	localparam logic [1:0] DIR_NORTH = 2'd3;

	// configuration register indexes
	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	// wall kinds
	localparam logic WALL_TOP  = 1'b0;
	localparam logic WALL_LEFT = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ENTER,
		ST_CHECK,
		ST_MAP_WAIT,
		ST_POP_WAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [1:0]         first;
		logic [TRIED_W-1:0] tried;
	} entry_t;

	typedef struct packed {
		logic clr_step;
		logic load_in;
		logic enter;
		logic try_dir;
		logic pop;
		logic load_top;
		logic take_nb;
		logic res_carve;
		logic res_done;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic need_clr;
		logic finished;
		logic depth_zero;
		logic tried_full;
		logic nb_border;
		logic nb_visited;
		logic out_busy;
	} stat_t;

endpackage

// ----- hdl/mbc_in_if.sv -----
// ----------------------------------------------------------------------------
// mbc_in_if
// Input item channel: carve request.
// ----------------------------------------------------------------------------
interface mbc_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [1:0] rand_dir;

	modport source (output valid, output mode, output rand_dir, input ready);
	modport sink   (input valid, input mode, input rand_dir, output ready);
endinterface

// ----- hdl/mbc_out_if.sv -----
// ----------------------------------------------------------------------------
// mbc_out_if
// Result item channel: removed wall and completion flag.
// ----------------------------------------------------------------------------
interface mbc_out_if;
	logic       valid;
	logic       ready;
	logic [4:0] wall_x;
	logic [4:0] wall_y;
	logic       wall_kind;
	logic       carved;
	logic       done_res;

	modport source (output valid, output wall_x, output wall_y, output wall_kind,
		output carved, output done_res, input ready);
	modport sink   (input valid, input wall_x, input wall_y, input wall_kind,
		input carved, input done_res, output ready);
endinterface

// ----- hdl/mbc_cfg_if.sv -----
// ----------------------------------------------------------------------------
// mbc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mbc_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [5:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/mbc_ram.sv -----
// ----------------------------------------------------------------------------
// mbc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/mbc_ctrl.sv -----
// ----------------------------------------------------------------------------
// mbc_ctrl
// Sequencer: map clearing, cell entry, direction search, backtrack, result.
// ----------------------------------------------------------------------------
module mbc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  mbc_pkg::stat_t stat,
	output mbc_pkg::cmd_t  cmd
);
	import mbc_pkg::*;

	state_t state_q, state_d;
	logic   after_q, after_d;   // clearing pass belongs to an item

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			after_q <= 1'b0;
		end else begin
			state_q <= state_d;
			after_q <= after_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		after_d = after_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat.clr_last) begin
					state_d = after_q ? ST_ENTER : ST_IDLE;
					after_d = 1'b0;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = stat.need_clr ? ST_CLEAR : ST_ENTER;
					after_d = stat.need_clr;
				end
			end
			ST_ENTER: begin
				state_d = stat.finished ? ST_EMIT : ST_CHECK;
			end
			ST_CHECK: begin
				if (stat.depth_zero) begin
					state_d = ST_EMIT;
				end else if (stat.tried_full) begin
					state_d = ST_POP_WAIT;
				end else if (!stat.nb_border) begin
					state_d = ST_MAP_WAIT;
				end
			end
			ST_MAP_WAIT: begin
				state_d = stat.nb_visited ? ST_CHECK : ST_EMIT;
			end
			ST_POP_WAIT: begin
				state_d = ST_CHECK;
			end
			ST_EMIT: begin
				if (!stat.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
			end
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_ENTER: begin
				if (stat.finished) begin
					cmd.res_done = 1'b1;
				end else begin
					cmd.enter = 1'b1;
				end
			end
			ST_CHECK: begin
				if (stat.depth_zero) begin
					cmd.res_done = 1'b1;
				end else if (stat.tried_full) begin
					cmd.pop = 1'b1;
				end else begin
					cmd.try_dir = 1'b1;
				end
			end
			ST_MAP_WAIT: begin
				if (!stat.nb_visited) begin
					cmd.take_nb   = 1'b1;
					cmd.res_carve = 1'b1;
				end
			end
			ST_POP_WAIT: begin
				cmd.load_top = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = !stat.out_busy;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ----- hdl/mbc_dp.sv -----
// ----------------------------------------------------------------------------
// mbc_dp
// Datapath: visited map with epoch marks, cell stack with top in registers,
// neighbour test, configuration and output register.
// ----------------------------------------------------------------------------
module mbc_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_ready,
	mbc_in_if.sink          in_item,
	mbc_out_if.source       res,
	mbc_cfg_if.sink         cfg,
	input  mbc_pkg::cmd_t   cmd,
	output mbc_pkg::stat_t  stat
);
	import mbc_pkg::*;

	logic [CFG_W-1:0]   grid_w_q, grid_h_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [CELL_AW-1:0] clr_cnt_q;
	logic [DEPTH_W-1:0] depth_q;
	logic               finished_q;
	logic [COORD_W-1:0] pend_x_q, pend_y_q;
	logic [1:0]         rdir_q;
	entry_t             top_q;
	logic [CFG_W-1:0]   nb_x_q, nb_y_q;
	logic               vert_q;

	logic [COORD_W-1:0] res_x_q, res_y_q;
	logic               res_kind_q, res_carved_q, res_done_q;
	logic               out_valid_q;

	logic [CFG_W-1:0]   w_lim, h_lim;
	logic [1:0]         dir;
	logic [CFG_W-1:0]   x6, y6, nb_x, nb_y;
	logic               nb_bad, nb_border;

	logic               map_we;
	logic [CELL_AW-1:0] map_waddr;
	logic [EPOCH_W-1:0] map_wdata, map_rdata;
	logic               stk_we;
	logic [ENTRY_W-1:0] stk_rdata;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_w_q <= CFG_W'(20);
			grid_h_q <= CFG_W'(20);
		end else if (cfg.valid) begin
			if (cfg.index == REG_GRID_WIDTH) begin
				grid_w_q <= cfg.data;
			end
			if (cfg.index == REG_GRID_HEIGHT) begin
				grid_h_q <= cfg.data;
			end
		end
	end

	// clamped limits, minus one
	always_comb begin
		if (grid_w_q < CFG_W'(3)) begin
			w_lim = CFG_W'(2);
		end else if (grid_w_q > CFG_W'(MAX_WIDTH)) begin
			w_lim = CFG_W'(MAX_WIDTH - 1);
		end else begin
			w_lim = grid_w_q - CFG_W'(1);
		end
		if (grid_h_q < CFG_W'(3)) begin
			h_lim = CFG_W'(2);
		end else if (grid_h_q > CFG_W'(MAX_HEIGHT)) begin
			h_lim = CFG_W'(MAX_HEIGHT - 1);
		end else begin
			h_lim = grid_h_q - CFG_W'(1);
		end
	end

	// neighbour of the stack top in the current direction
	always_comb begin
		dir    = top_q.first + top_q.tried[1:0];
		x6     = {1'b0, top_q.x};
		y6     = {1'b0, top_q.y};
		nb_x   = x6;
		nb_y   = y6;
		nb_bad = 1'b0;
		case (dir)
			DIR_WEST: begin
				nb_bad = (top_q.x == '0);
				nb_x   = x6 - CFG_W'(1);
			end
			DIR_SOUTH: nb_y = y6 + CFG_W'(1);
			DIR_EAST:  nb_x = x6 + CFG_W'(1);
			DIR_NORTH: begin
				nb_bad = (top_q.y == '0);
				nb_y   = y6 - CFG_W'(1);
			end
			default: nb_bad = 1'b1;
		endcase
		nb_border = nb_bad || nb_x == '0 || nb_y == '0 || nb_x >= w_lim || nb_y >= h_lim;
	end

	// maze state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q    <= EPOCH_W'(1);
			clr_cnt_q  <= '0;
			depth_q    <= '0;
			finished_q <= 1'b0;
			pend_x_q   <= COORD_W'(1);
			pend_y_q   <= COORD_W'(1);
		end else begin
			if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + CELL_AW'(1);
				if (clr_cnt_q == '1) begin
					epoch_q <= EPOCH_W'(1);
				end
			end
			if (cmd.load_in && !in_item.mode) begin
				if (epoch_q != EPOCH_MAX) begin
					epoch_q <= epoch_q + EPOCH_W'(1);
				end
				depth_q    <= '0;
				finished_q <= 1'b0;
				pend_x_q   <= COORD_W'(1);
				pend_y_q   <= COORD_W'(1);
			end
			if (cmd.enter && depth_q < DEPTH_W'(STACK_DEPTH)) begin
				depth_q <= depth_q + DEPTH_W'(1);
			end
			if (cmd.pop) begin
				depth_q <= depth_q - DEPTH_W'(1);
			end
			if (cmd.res_done) begin
				finished_q <= 1'b1;
			end
			if (cmd.take_nb) begin
				pend_x_q <= nb_x_q[COORD_W-1:0];
				pend_y_q <= nb_y_q[COORD_W-1:0];
			end
		end
	end

	// payload registers: request, stack top, neighbour, result
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			rdir_q <= in_item.rand_dir;
		end
		if (cmd.enter && depth_q < DEPTH_W'(STACK_DEPTH)) begin
			top_q <= '{x: pend_x_q, y: pend_y_q, first: rdir_q, tried: '0};
		end else if (cmd.try_dir) begin
			top_q.tried <= top_q.tried + TRIED_W'(1);
		end else if (cmd.load_top) begin
			top_q <= entry_t'(stk_rdata);
		end
		if (cmd.try_dir) begin
			nb_x_q <= nb_x;
			nb_y_q <= nb_y;
			vert_q <= (nb_x == x6);
		end
		if (cmd.res_carve) begin
			res_carved_q <= 1'b1;
			res_done_q   <= 1'b0;
			if (vert_q) begin
				res_x_q    <= top_q.x;
				res_y_q    <= (nb_y_q > y6) ? nb_y_q[COORD_W-1:0] : top_q.y;
				res_kind_q <= WALL_TOP;
			end else begin
				res_x_q    <= (nb_x_q > x6) ? nb_x_q[COORD_W-1:0] : top_q.x;
				res_y_q    <= top_q.y;
				res_kind_q <= WALL_LEFT;
			end
		end else if (cmd.res_done) begin
			res_carved_q <= 1'b0;
			res_done_q   <= 1'b1;
			res_x_q      <= '0;
			res_y_q      <= '0;
			res_kind_q   <= WALL_TOP;
		end
		if (cmd.emit) begin
			res.wall_x    <= res_x_q;
			res.wall_y    <= res_y_q;
			res.wall_kind <= res_kind_q;
			res.carved    <= res_carved_q;
			res.done_res  <= res_done_q;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end
	assign res.valid = out_valid_q;

	// visited map: an entry is visited when it holds the current epoch
	assign map_we    = cmd.clr_step || cmd.enter;
	assign map_waddr = cmd.clr_step ? clr_cnt_q : {pend_y_q, pend_x_q};
	assign map_wdata = cmd.clr_step ? '0 : epoch_q;

	mbc_ram #(.WIDTH(EPOCH_W), .DEPTH(STACK_DEPTH)) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.re    (cmd.try_dir),
		.raddr ({nb_y[COORD_W-1:0], nb_x[COORD_W-1:0]}),
		.rdata (map_rdata)
	);

	// cell stack: entries below the top, top itself in top_q
	assign stk_we = cmd.enter && depth_q != '0 && depth_q < DEPTH_W'(STACK_DEPTH);

	mbc_ram #(.WIDTH(ENTRY_W), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (CELL_AW'(depth_q - DEPTH_W'(1))),
		.wdata (ENTRY_W'(top_q)),
		.re    (cmd.pop),
		.raddr (CELL_AW'(depth_q - DEPTH_W'(2))),
		.rdata (stk_rdata)
	);

	// status
	assign in_item.ready   = in_ready;
	assign stat.clr_last   = (clr_cnt_q == '1);
	assign stat.need_clr   = !in_item.mode && epoch_q == EPOCH_MAX;
	assign stat.finished   = finished_q;
	assign stat.depth_zero = (depth_q == '0);
	assign stat.tried_full = (top_q.tried == TRIED_W'(DIR_COUNT));
	assign stat.nb_border  = nb_border;
	assign stat.nb_visited = (map_rdata == epoch_q);
	assign stat.out_busy   = out_valid_q && !res.ready;

	// checks
	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(STACK_DEPTH))
		else $error("stack depth beyond capacity");
	a_try_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.try_dir |-> (top_q.tried < TRIED_W'(DIR_COUNT) && depth_q != '0))
		else $error("direction tried on exhausted or empty top");
	a_carve_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_carve |=> (res_carved_q && !res_done_q))
		else $error("carve result flagged as done");
	a_enter_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.enter |-> !finished_q)
		else $error("cell entered on finished maze");

endmodule

// ----- hdl/maze_backtracker_carver.sv -----
// States: a carve on the first direction tried passes idle, enter, check, map wait
// and emit; each further direction adds check (ring cell) or check and map wait
// (visited-map read), each backtrack pop check and pop wait. One item at a time: the
// next item is taken once the result is in the output register. Per-direction cost is
// set by the single registered map read port. Reset: asynchronous, active low; the
// visited map is cleared after reset and every fifteenth new maze, with no item taken meanwhile.
// ----------------------------------------------------------------------------
// maze_backtracker_carver
// Depth-first maze carver: one removed wall, or done, per item.
// ----------------------------------------------------------------------------
module maze_backtracker_carver (
	input  logic      clk,
	input  logic      arst_n,
	mbc_in_if.sink    in_item,
	mbc_out_if.source res,
	mbc_cfg_if.sink   cfg
);
	import mbc_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  ctrl_ready;

	// sequencer
	mbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_item.valid),
		.in_ready (ctrl_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath
	mbc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ready (ctrl_ready),
		.in_item  (in_item),
		.res      (res),
		.cfg      (cfg),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule
